/* hw/rtl/twsc_pkg.sv */
// Shared types and constants of the trace wavelet same-mode convolution.
package twsc_pkg;

    localparam int MAX_TAPS      = 64;
    localparam int TAP_AW        = 6;
    localparam int MAX_TRACE_LEN = 4096;
    localparam int CNT_W         = 13;
    localparam int TAPS_W        = 7;
    localparam int OFS_W         = 5;
    localparam int FILL_W        = 7;
    localparam int ACC_W         = 38;
    localparam int SMP_W         = 16;
    localparam int RES_W         = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;

    // Input item kinds
    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic [TAPS_W-1:0]         taps_t;
    typedef logic [OFS_W-1:0]          ofs_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [RES_W-1:0]   res_word_t;

    localparam acc_t SAT_HI = acc_t'(64'sd2147483647);
    localparam acc_t SAT_LO = acc_t'(-64'sd2147483648);

    typedef struct packed {
        logic                    kind;
        logic [TAP_AW-1:0]       tap_index;
        logic signed [SMP_W-1:0] coefficient;
        logic signed [SMP_W-1:0] sample;
        logic                    trace_end;
    } item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] result;
        logic                    burst_end;
        logic                    trace_done;
    } result_t;

    // Classified work handed from the front part to the back part
    typedef struct packed {
        logic                    is_sample;
        logic [TAP_AW-1:0]       tap_index;
        logic signed [SMP_W-1:0] coefficient;
        logic signed [SMP_W-1:0] sample;
        logic                    trace_end;
        logic                    emit_now;
        ofs_t                    zero_shifts;
        ofs_t                    zero_skip;
        taps_t                   taps;
    } cmd_t;

endpackage

/* hw/rtl/twsc_front.sv */
// Front part: takes input items, tracks the sample count and classifies each item.
module twsc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  twsc_pkg::item_t     item_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  twsc_pkg::taps_t     cfg_data,
    input  logic                q_full,
    output logic                push,
    output twsc_pkg::cmd_t      push_cmd
);

    twsc_pkg::taps_t tap_count_reg;
    twsc_pkg::cnt_t  sample_count_reg;
    twsc_pkg::cnt_t  sample_count_next;
    twsc_pkg::taps_t taps;
    twsc_pkg::ofs_t  offset;
    twsc_pkg::cnt_t  k_plus;
    twsc_pkg::ofs_t  trail;

    assign cfg_ready  = 1'b1;
    assign item_stall = q_full;
    assign push       = item_valid && !q_full;

    // Clamp the tap count into 1..MAX_TAPS and derive the crop offset
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps = twsc_pkg::taps_t'(1);
        end
        else if (tap_count_reg > twsc_pkg::taps_t'(twsc_pkg::MAX_TAPS))
        begin
            taps = twsc_pkg::taps_t'(twsc_pkg::MAX_TAPS);
        end
        else
        begin
            taps = tap_count_reg;
        end
        offset = twsc_pkg::ofs_t'((taps - twsc_pkg::taps_t'(1)) >> 1);
        k_plus = sample_count_reg + twsc_pkg::cnt_t'(1);
        if (k_plus < twsc_pkg::cnt_t'(offset))
        begin
            trail = k_plus[twsc_pkg::OFS_W-1:0];
        end
        else
        begin
            trail = offset;
        end
    end

    // Build the command for the back part
    always_comb
    begin
        push_cmd.is_sample   = (item_data.kind == twsc_pkg::KIND_SAMPLE);
        push_cmd.tap_index   = item_data.tap_index;
        push_cmd.coefficient = item_data.coefficient;
        push_cmd.sample      = item_data.sample;
        push_cmd.trace_end   = item_data.trace_end;
        push_cmd.emit_now    = (sample_count_reg >= twsc_pkg::cnt_t'(offset));
        push_cmd.zero_shifts = offset;
        push_cmd.zero_skip   = offset - trail;
        push_cmd.taps        = taps;
    end

    // Advance the per-trace sample count, saturating on overlong traces
    always_comb
    begin
        sample_count_next = sample_count_reg;
        if (push && item_data.kind == twsc_pkg::KIND_SAMPLE)
        begin
            if (item_data.trace_end)
            begin
                sample_count_next = '0;
            end
            else if (sample_count_reg < twsc_pkg::cnt_t'(twsc_pkg::MAX_TRACE_LEN))
            begin
                sample_count_next = k_plus;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg    <= twsc_pkg::taps_t'(1);
            sample_count_reg <= '0;
        end
        else
        begin
            sample_count_reg <= sample_count_next;
            if (cfg_valid && cfg_ready)
            begin
                tap_count_reg <= cfg_data;
            end
        end
    end

endmodule

/* hw/rtl/twsc_queue.sv */
// Short command queue between the front and back parts.
module twsc_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  twsc_pkg::cmd_t  push_cmd,
    output logic            q_full,
    input  logic            pop,
    output twsc_pkg::cmd_t  pop_cmd,
    output logic            q_empty
);

    twsc_pkg::cmd_t                  entry_reg [twsc_pkg::QUEUE_DEPTH];
    logic [twsc_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [twsc_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [twsc_pkg::QUEUE_AW:0]     count_reg;

    assign q_full  = (count_reg == (twsc_pkg::QUEUE_AW+1)'(twsc_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + twsc_pkg::QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + twsc_pkg::QUEUE_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (twsc_pkg::QUEUE_AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (twsc_pkg::QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

/* hw/rtl/twsc_back.sv */
// Back part: tap memory, sample history and the shared multiply-accumulate sequencer.
module twsc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  twsc_pkg::cmd_t      pop_cmd,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_stall,
    output twsc_pkg::result_t   res_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_PUT,
        S_NEXT
    } state_t;

    state_t                          state_reg;
    twsc_pkg::cmd_t                  cmd_reg;
    logic [twsc_pkg::TAP_AW-1:0]     wp_reg;
    logic [twsc_pkg::FILL_W-1:0]     fill_reg;
    twsc_pkg::ofs_t                  zcnt_reg;
    twsc_pkg::ofs_t                  zrem_reg;
    twsc_pkg::ofs_t                  skip_reg;
    logic [twsc_pkg::TAP_AW-1:0]     tap_i_reg;
    logic                            last_reg;
    logic                            s1_v_reg;
    logic                            s2_v_reg;
    logic                            res_valid_reg;
    twsc_pkg::result_t               res_reg;

    logic signed [twsc_pkg::SMP_W-1:0] tap_mem [twsc_pkg::MAX_TAPS];
    logic signed [twsc_pkg::SMP_W-1:0] hist_mem [twsc_pkg::MAX_TAPS];
    logic signed [twsc_pkg::SMP_W-1:0] tap_rd_reg;
    logic signed [twsc_pkg::SMP_W-1:0] hist_rd_reg;
    logic                              s1_zero_reg;
    logic signed [twsc_pkg::RES_W-1:0] prod_reg;
    twsc_pkg::acc_t                    acc_reg;

    logic                            take_load;
    logic                            take_sample;
    logic                            issue;
    logic                            issue_end;
    logic                            zero_step;
    logic                            mac_start;
    logic                            put_ok;
    logic [twsc_pkg::TAP_AW-1:0]     hist_addr;
    logic                            tap_zero;
    logic [twsc_pkg::TAP_AW-1:0]     last_tap;
    twsc_pkg::res_word_t             sat_value;

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Decode the current step of the sequencer
    always_comb
    begin
        pop         = (state_reg == S_IDLE) && !q_empty;
        take_load   = pop && !pop_cmd.is_sample;
        take_sample = pop && pop_cmd.is_sample;
        issue       = (state_reg == S_MAC);
        last_tap    = twsc_pkg::TAP_AW'(cmd_reg.taps - twsc_pkg::taps_t'(1));
        issue_end   = issue && (tap_i_reg == last_tap);
        zero_step   = (state_reg == S_NEXT) && (zrem_reg != '0);
        mac_start   = (take_sample && pop_cmd.emit_now) || (zero_step && skip_reg == '0);
        put_ok      = (state_reg == S_PUT) && (!res_valid_reg || !res_stall);
        hist_addr   = wp_reg - twsc_pkg::TAP_AW'(1) - tap_i_reg;
        tap_zero    = (twsc_pkg::ofs_t'(tap_i_reg) < zcnt_reg && tap_i_reg < 6'd32)
                      || (twsc_pkg::FILL_W'(tap_i_reg) >= fill_reg);
    end

    // Saturate the finished sum to 32 bits
    always_comb
    begin
        if (acc_reg > twsc_pkg::SAT_HI)
        begin
            sat_value = twsc_pkg::res_word_t'(twsc_pkg::SAT_HI);
        end
        else if (acc_reg < twsc_pkg::SAT_LO)
        begin
            sat_value = twsc_pkg::res_word_t'(twsc_pkg::SAT_LO);
        end
        else
        begin
            sat_value = acc_reg[twsc_pkg::RES_W-1:0];
        end
    end

    // Tap memory: written by loads, read by the tap walk
    always_ff @(posedge clk)
    begin
        if (take_load)
        begin
            tap_mem[pop_cmd.tap_index] <= pop_cmd.coefficient;
        end
        if (issue)
        begin
            tap_rd_reg <= tap_mem[tap_i_reg];
        end
    end

    // Sample history: circular buffer, newest sample just below the write pointer
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            hist_mem[wp_reg] <= pop_cmd.sample;
        end
        if (issue)
        begin
            hist_rd_reg <= hist_mem[hist_addr];
        end
    end

    // Multiply and accumulate datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= pop_cmd;
        end
        if (issue)
        begin
            s1_zero_reg <= tap_zero;
        end
        if (s1_zero_reg)
        begin
            prod_reg <= '0;
        end
        else
        begin
            prod_reg <= twsc_pkg::res_word_t'(tap_rd_reg) * twsc_pkg::res_word_t'(hist_rd_reg);
        end
        if (mac_start)
        begin
            acc_reg <= '0;
        end
        else if (s2_v_reg)
        begin
            acc_reg <= acc_reg + twsc_pkg::acc_t'(prod_reg);
        end
    end

    // Sequencer state, history bookkeeping and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            zcnt_reg      <= '0;
            zrem_reg      <= '0;
            skip_reg      <= '0;
            tap_i_reg     <= '0;
            last_reg      <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
            if (res_valid_reg && !res_stall && !put_ok)
            begin
                res_valid_reg <= 1'b0;
            end
            if (mac_start)
            begin
                tap_i_reg <= '0;
            end
            else if (issue)
            begin
                tap_i_reg <= tap_i_reg + twsc_pkg::TAP_AW'(1);
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (take_sample)
                    begin
                        wp_reg   <= wp_reg + twsc_pkg::TAP_AW'(1);
                        if (fill_reg != twsc_pkg::FILL_W'(twsc_pkg::MAX_TAPS))
                        begin
                            fill_reg <= fill_reg + twsc_pkg::FILL_W'(1);
                        end
                        zcnt_reg <= '0;
                        zrem_reg <= pop_cmd.trace_end ? pop_cmd.zero_shifts : '0;
                        skip_reg <= pop_cmd.zero_skip;
                        last_reg <= !(pop_cmd.trace_end && pop_cmd.zero_shifts != '0);
                        state_reg <= pop_cmd.emit_now ? S_MAC : S_NEXT;
                    end
                end
                S_MAC:
                begin
                    if (issue_end)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    // wait until the last product has landed in the sum
                    if (!s1_v_reg && !s2_v_reg)
                    begin
                        state_reg <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (put_ok)
                    begin
                        res_valid_reg       <= 1'b1;
                        res_reg.result      <= sat_value;
                        res_reg.burst_end   <= last_reg;
                        res_reg.trace_done  <= last_reg && cmd_reg.trace_end;
                        state_reg           <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (zero_step)
                    begin
                        // shift in a zero past the trace end
                        wp_reg   <= wp_reg + twsc_pkg::TAP_AW'(1);
                        if (fill_reg != twsc_pkg::FILL_W'(twsc_pkg::MAX_TAPS))
                        begin
                            fill_reg <= fill_reg + twsc_pkg::FILL_W'(1);
                        end
                        zcnt_reg <= zcnt_reg + twsc_pkg::ofs_t'(1);
                        zrem_reg <= zrem_reg - twsc_pkg::ofs_t'(1);
                        if (skip_reg != '0)
                        begin
                            skip_reg <= skip_reg - twsc_pkg::ofs_t'(1);
                        end
                        else
                        begin
                            last_reg  <= (zrem_reg == twsc_pkg::ofs_t'(1));
                            state_reg <= S_MAC;
                        end
                    end
                    else
                    begin
                        // clear the history at the end of a trace
                        if (cmd_reg.trace_end)
                        begin
                            fill_reg <= '0;
                            zcnt_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/trace_wavelet_same_convolution.sv */
// Top level of the trace wavelet same-mode convolution.
// Convolves each trace with the loaded wavelet and returns the centered part of the full
// convolution, one result per trace sample. In the back part a tap load only writes the tap
// memory and a sample that yields no result only steps on. For a sample that yields a
// result, tap_count clamped to 1..64, the sequencer takes the command, a single
// multiply-accumulate unit walks the tap memory and the sample history memory, the last
// products pass the read and multiply stages into the sum, the result register is loaded
// and the sequencer steps on. At a trace end, each of the floor((tap_count-1)/2) trailing
// zero shifts that yields a result goes through the same tap walk, and each one that yields
// none only steps on. A four-entry command queue lets input transfers continue while the
// multiply-accumulate unit is busy, and a result register holds a finished result while the
// next one is computed; the sequencer waits only when a second result is ready before the
// first has been taken.
module trace_wavelet_same_convolution
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  twsc_pkg::item_t      item_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output twsc_pkg::result_t    res_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  twsc_pkg::taps_t      cfg_data
);

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    twsc_pkg::cmd_t  push_cmd;
    twsc_pkg::cmd_t  pop_cmd;

    // Accept and classify items
    twsc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Hold pending commands
    twsc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_empty  (q_empty)
    );

    // Execute commands and produce results
    twsc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

`ifndef NO_ASSERTIONS
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_empty)
        else $error("queue empty right after a push");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("command taken from an empty queue");

    a_done_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.trace_done) |-> res_data.burst_end)
        else $error("trace end result not marked as end of burst");
`endif

endmodule

/* verif/trace_wavelet_same_convolution_tb.sv */
// Testbench for the trace wavelet same-mode convolution: directed rows, then random traces.
module trace_wavelet_same_convolution_tb;

    localparam int IDLE_PCT       = 29;
    localparam int TOTAL_ITEMS    = 110;
    localparam int SETTLE_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SHOWN_FAULTS   = 10;

    typedef enum int { ROW_LOAD, ROW_SAMPLE, ROW_TAPS } row_op_e;

    // One directed row: a tap load, a trace sample or a tap count write
    typedef struct {
        row_op_e     op;
        int          idx;
        int          value;
        bit          te;
        bit          lit;
        longint      want;
        bit          want_be;
        bit          want_td;
    } dir_row_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    twsc_pkg::item_t      item_data  = '0;
    logic                 res_valid;
    logic                 res_stall  = 1'b0;
    twsc_pkg::result_t    res_data;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    twsc_pkg::taps_t      cfg_data   = twsc_pkg::taps_t'(1);

    bit      calm = 1'b0;
    int      fault_count = 0;
    int      idle_cycles = 0;
    int      items_sent = 0;

    // Predicted state of the convolver
    logic signed [twsc_pkg::SMP_W-1:0] wavelet [twsc_pkg::MAX_TAPS];
    bit                                wavelet_loaded [twsc_pkg::MAX_TAPS];
    logic signed [twsc_pkg::SMP_W-1:0] history [twsc_pkg::MAX_TAPS];
    int unsigned                       trace_pos = 0;
    twsc_pkg::taps_t                   tap_setting = twsc_pkg::taps_t'(1);

    twsc_pkg::result_t fresh_outputs [$];
    twsc_pkg::result_t awaited_outputs [$];

    dir_row_t directed_rows [24] = '{
        '{ROW_LOAD,   0,  32767, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_SAMPLE, 0,  32767, 1'b1, 1'b1, 1073676289,   1'b1, 1'b1},
        '{ROW_SAMPLE, 0, -32768, 1'b1, 1'b1, -1073709056,  1'b1, 1'b1},
        '{ROW_LOAD,   0, -32768, 1'b1, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_SAMPLE, 0, -32768, 1'b1, 1'b1, 1073741824,   1'b1, 1'b1},
        '{ROW_TAPS,   0,      0, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_SAMPLE, 0,      1, 1'b0, 1'b1, -32768,       1'b1, 1'b0},
        '{ROW_SAMPLE, 0,      0, 1'b1, 1'b1, 0,            1'b1, 1'b1},
        '{ROW_LOAD,   1, -32768, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_TAPS,   0,      2, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_SAMPLE, 0, -32768, 1'b0, 1'b1, 1073741824,   1'b1, 1'b0},
        '{ROW_SAMPLE, 0, -32768, 1'b1, 1'b1, 2147483647,   1'b1, 1'b1},
        '{ROW_LOAD,   2, -32768, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_TAPS,   0,      3, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_SAMPLE, 0,  32767, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_SAMPLE, 0,  32767, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_LOAD,   1,  12345, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_SAMPLE, 0,  32767, 1'b1, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_SAMPLE, 0,     -1, 1'b1, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_LOAD,   3,      7, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_TAPS,   0,      4, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_SAMPLE, 0,    100, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_TAPS,   0,      1, 1'b0, 1'b0, 0,            1'b0, 1'b0},
        '{ROW_SAMPLE, 0,    200, 1'b1, 1'b0, 0,            1'b0, 1'b0}
    };

    trace_wavelet_same_convolution u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Clamp the tap count to the usable range
    function automatic int taps_active();
        if (tap_setting == '0)
            return 1;
        if (int'(tap_setting) > twsc_pkg::MAX_TAPS)
            return twsc_pkg::MAX_TAPS;
        return int'(tap_setting);
    endfunction

    // Dot product of the wavelet with the history, saturated to 32 bits
    function automatic twsc_pkg::res_word_t wavelet_dot(int taps);
        longint acc;
        acc = 0;
        for (int i = 0; i < taps; i++)
            acc += longint'(wavelet[i]) * longint'(history[i]);
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return twsc_pkg::res_word_t'(acc);
    endfunction

    function automatic void shift_history(logic signed [twsc_pkg::SMP_W-1:0] x);
        for (int i = twsc_pkg::MAX_TAPS - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = x;
    endfunction

    function automatic void push_output(twsc_pkg::res_word_t value);
        twsc_pkg::result_t r;
        r.result     = value;
        r.burst_end  = 1'b0;
        r.trace_done = 1'b0;
        fresh_outputs.push_back(r);
    endfunction

    // Compute the outputs that one accepted item causes
    function automatic void convolve_item(twsc_pkg::item_t it);
        int taps;
        int ofs;
        int unsigned k;
        fresh_outputs.delete();
        if (it.kind == twsc_pkg::KIND_TAP)
        begin
            wavelet[it.tap_index]        = it.coefficient;
            wavelet_loaded[it.tap_index] = 1'b1;
            return;
        end
        taps = taps_active();
        ofs  = (taps - 1) / 2;
        k    = trace_pos;
        if (trace_pos < twsc_pkg::MAX_TRACE_LEN)
            trace_pos++;
        shift_history(it.sample);
        if (k >= ofs)
            push_output(wavelet_dot(taps));
        if (it.trace_end)
        begin
            // Flush the trailing outputs with zeros past the trace end
            for (int unsigned j = k + 1; j < k + 1 + ofs; j++)
            begin
                shift_history('0);
                if (j >= ofs)
                    push_output(wavelet_dot(taps));
            end
            if (fresh_outputs.size() > 0)
                fresh_outputs[fresh_outputs.size()-1].trace_done = 1'b1;
            for (int i = 0; i < twsc_pkg::MAX_TAPS; i++)
                history[i] = '0;
            trace_pos = 0;
        end
        if (fresh_outputs.size() > 0)
            fresh_outputs[fresh_outputs.size()-1].burst_end = 1'b1;
    endfunction

    function automatic logic signed [twsc_pkg::SMP_W-1:0] rand_q15();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            default: return twsc_pkg::SMP_W'($urandom);
        endcase
    endfunction

    function automatic twsc_pkg::item_t make_load(int idx,
                                                  logic signed [twsc_pkg::SMP_W-1:0] coef,
                                                  bit te);
        twsc_pkg::item_t it;
        it.kind        = twsc_pkg::KIND_TAP;
        it.tap_index   = twsc_pkg::TAP_AW'(idx);
        it.coefficient = coef;
        it.sample      = twsc_pkg::SMP_W'($urandom);
        it.trace_end   = te;
        return it;
    endfunction

    function automatic twsc_pkg::item_t make_sample(logic signed [twsc_pkg::SMP_W-1:0] smp,
                                                    bit te);
        twsc_pkg::item_t it;
        it.kind        = twsc_pkg::KIND_SAMPLE;
        it.tap_index   = twsc_pkg::TAP_AW'($urandom);
        it.coefficient = twsc_pkg::SMP_W'($urandom);
        it.sample      = smp;
        it.trace_end   = te;
        return it;
    endfunction

    // Offer one item, idling at random first, and record its outputs on transfer
    task automatic send_item(twsc_pkg::item_t it, bit lit, twsc_pkg::result_t want);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        convolve_item(it);
        if (lit)
            awaited_outputs.push_back(want);
        else
            foreach (fresh_outputs[i])
                awaited_outputs.push_back(fresh_outputs[i]);
    endtask

    // Write the tap count once the block has gone idle
    task automatic write_taps(twsc_pkg::taps_t value);
        item_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tap_setting = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic load_missing_taps();
        for (int i = 0; i < taps_active(); i++)
            if (!wavelet_loaded[i] || $urandom_range(7) == 0)
                send_item(make_load(i, rand_q15(), 1'(($urandom_range(1)))), 1'b0, '0);
    endtask

    // Stall the result channel at random
    always @(posedge clk)
        res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        twsc_pkg::result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (awaited_outputs.size() == 0)
            begin
                fault_count++;
                if (fault_count <= SHOWN_FAULTS)
                    $display("unexpected result %0d be=%0d td=%0d", res_data.result,
                             res_data.burst_end, res_data.trace_done);
            end
            else
            begin
                want = awaited_outputs.pop_front();
                if (res_data.result !== want.result || res_data.burst_end !== want.burst_end
                    || res_data.trace_done !== want.trace_done)
                begin
                    fault_count++;
                    if (fault_count <= SHOWN_FAULTS)
                        $display("mismatch: expected %0d be=%0d td=%0d, got %0d be=%0d td=%0d",
                                 want.result, want.burst_end, want.trace_done,
                                 res_data.result, res_data.burst_end, res_data.trace_done);
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        dir_row_t            row;
        twsc_pkg::result_t   want;
        twsc_pkg::taps_t     setting;
        int                  phase;
        int                  traces;
        int                  len;
        bit                  close_trace;

        for (int i = 0; i < twsc_pkg::MAX_TAPS; i++)
        begin
            wavelet[i]        = '0;
            wavelet_loaded[i] = 1'b0;
            history[i]        = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            want.result     = twsc_pkg::res_word_t'(row.want);
            want.burst_end  = row.want_be;
            want.trace_done = row.want_td;
            case (row.op)
                ROW_TAPS:   write_taps(twsc_pkg::taps_t'(row.value));
                ROW_LOAD:   send_item(make_load(row.idx, twsc_pkg::SMP_W'(row.value), row.te),
                                      1'b0, want);
                ROW_SAMPLE: send_item(make_sample(twsc_pkg::SMP_W'(row.value), row.te),
                                      row.lit, want);
                default:    ;
            endcase
        end

        // Random phases: one tap count each, a wavelet load, then traces
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            case (phase % 6)
                0:       setting = twsc_pkg::taps_t'(3);
                1:       setting = twsc_pkg::taps_t'(127);
                2:       setting = twsc_pkg::taps_t'($urandom_range(1, 127));
                3:       setting = twsc_pkg::taps_t'(0);
                4:       setting = twsc_pkg::taps_t'(64);
                default: setting = twsc_pkg::taps_t'(1);
            endcase
            write_taps(setting);
            calm = (phase == 1);
            load_missing_taps();
            traces = $urandom_range(1, 2);
            for (int tr = 0; tr < traces; tr++)
            begin
                len = $urandom_range(1, 6);
                // Leave the last trace open now and then so the next count applies mid trace
                close_trace = (tr != traces - 1) || ($urandom_range(2) != 0);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(9) == 0)
                        send_item(make_load($urandom_range(63), rand_q15(),
                                            1'($urandom_range(1))), 1'b0, '0);
                    send_item(make_sample(rand_q15(), close_trace && i == len - 1), 1'b0, '0);
                end
            end
            phase++;
        end
        calm = 1'b0;

        // Drain and settle
        item_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
